[rtl/core/nearest_point_search_top_macros.svh]
// Assertion macros shared by the nearest point search RTL.
`ifndef NEAREST_POINT_SEARCH_TOP_MACROS_SVH
`define NEAREST_POINT_SEARCH_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define NPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nearest point search: implication check failed");

`define NPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nearest point search: next-cycle check failed");

`else

`define NPS_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define NPS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/nps_pkg.sv]
// Types and constants shared by the nearest point search modules.
`timescale 1ns / 1ps

package nps_pkg;

  localparam int COORD_W = 24;
  localparam int ABS_W   = 24;
  localparam int SQR_W   = 48;
  localparam int SQ_W    = 49;
  localparam int RAD_W   = 50;
  localparam int DIST_W  = 25;
  localparam int IDX_W   = 9;
  localparam int CNT_W   = 9;
  localparam int EXT_W   = 17;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_REEF_COUNT = 1'b0;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
  } scan_tag_t;

endpackage

[rtl/core/nps_point_mem.sv]
// Reference point memory with one write port and one registered read port.
`timescale 1ns / 1ps

module nps_point_mem
  import nps_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  point_t            wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output point_t            rd_data
);

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/nps_dist_unit.sv]
// Three-stage pipeline that forms the squared distance to one stored point.
`timescale 1ns / 1ps

module nps_dist_unit
  import nps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [COORD_W-1:0] qx,
  input  logic [COORD_W-1:0] qy,
  input  scan_tag_t          in_tag,
  input  point_t             in_point,
  output scan_tag_t          sq_tag,
  output logic [SQ_W-1:0]    sq,
  output logic               busy
);

  logic [COORD_W:0] dx;
  logic [COORD_W:0] dy;
  logic [COORD_W:0] ndx;
  logic [COORD_W:0] ndy;
  scan_tag_t        abs_tag;
  logic [ABS_W-1:0] ax;
  logic [ABS_W-1:0] ay;
  scan_tag_t        sqr_tag;
  logic [SQR_W-1:0] sx;
  logic [SQR_W-1:0] sy;

  assign dx  = {qx[COORD_W-1], qx} - {in_point.x[COORD_W-1], in_point.x};
  assign dy  = {qy[COORD_W-1], qy} - {in_point.y[COORD_W-1], in_point.y};
  assign ndx = '0 - dx;
  assign ndy = '0 - dy;

  always_ff @(posedge clk) begin
    abs_tag.index <= in_tag.index;
    ax            <= dx[COORD_W] ? ndx[ABS_W-1:0] : dx[ABS_W-1:0];
    ay            <= dy[COORD_W] ? ndy[ABS_W-1:0] : dy[ABS_W-1:0];
    sqr_tag.index <= abs_tag.index;
    sx            <= ax * ax;
    sy            <= ay * ay;
    sq_tag.index  <= sqr_tag.index;
    sq            <= SQ_W'(sx) + SQ_W'(sy);
    if (rst) begin
      abs_tag.valid <= 1'b0;
      sqr_tag.valid <= 1'b0;
      sq_tag.valid  <= 1'b0;
    end else begin
      abs_tag.valid <= in_tag.valid;
      sqr_tag.valid <= abs_tag.valid;
      sq_tag.valid  <= sqr_tag.valid;
    end
  end

  assign busy = abs_tag.valid | sqr_tag.valid | sq_tag.valid;

endmodule

[rtl/core/nps_isqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module nps_isqrt
  import nps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   value,
  output logic [DIST_W-1:0] root,
  output logic              done
);

  localparam int REM_W  = DIST_W + 1;
  localparam int WIDE_W = DIST_W + 3;
  localparam logic [4:0] LAST_STEP = 5'(DIST_W - 1);

  logic              busy;
  logic [4:0]        step;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [WIDE_W-1:0] rem_sh;
  logic [WIDE_W-1:0] trial;
  logic              take;

  assign rem_sh = {rem, rad[RAD_W-1:RAD_W-2]};
  assign trial  = WIDE_W'({root, 2'b01});
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'(value);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root <= {root[DIST_W-2:0], take};
    end
  end

endmodule

[rtl/core/nearest_point_search_top.sv]
// Nearest point search: point table, scan control, register port and result stage.
`timescale 1ns / 1ps
`include "nearest_point_search_top_macros.svh"

// Usage:
// Input items arrive on in_valid/in_stall with command, entry_index, x_coord and
// y_coord. A write item (command 0) stores a point when it is taken; it gives no
// result, so writes may follow each other in every cycle while no query runs.
// A query item (command 1) scans the first reef_count table entries, at most
// MAX_POINTS, one memory read per cycle, through a three-stage distance pipeline,
// then, with at least one entry scanned, runs a 25-step square root; the single
// memory read port and the one-bit-per-cycle root unit set its pace. An empty
// scan skips the square root.
// While a query is in progress in_stall stays high.
// Each query gives one result item on out_valid/out_stall: distance and the
// 1-based nearest_index; an empty scan gives all ones and index 0.
// A finished result waits in the output register while the receiver stalls;
// new items are taken meanwhile, and a second result waits until it drains.
// reef_count is written over the APB port at byte address 0.
// Reset clears reef_count and the control state; the point table is not cleared,
// so every scanned entry must be written first.

module nearest_point_search_top
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [7:0]                entry_index,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DIST_W-1:0]         distance,
  output logic [IDX_W-1:0]          nearest_index,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_POINTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [CNT_W-1:0]   reef_count;
  logic [CNT_W-1:0]   scan_limit;
  logic [CNT_W-1:0]   scan_addr;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic               found;
  logic [SQ_W-1:0]    best_sq;
  logic [IDX_W-1:0]   best_idx;
  scan_tag_t          rd_tag;
  scan_tag_t          sq_tag;
  logic [SQ_W-1:0]    sq;
  logic               dist_busy;
  point_t             rd_point;
  point_t             wr_point;
  logic               in_acc;
  logic               wr_en;
  logic               query_acc;
  logic               issue;
  logic               root_start;
  logic               root_done;
  logic [DIST_W-1:0]  root;
  logic               load;
  logic               cfg_wr;
  logic [EXT_W-1:0]   wr_ext;
  logic [EXT_W-1:0]   rd_ext;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_REEF_COUNT);
  assign prdata = (paddr[2] == REG_REEF_COUNT) ? PDATA_W'(reef_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reef_count <= '0;
    end else if (cfg_wr) begin
      reef_count <= pwdata[CNT_W-1:0];
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign query_acc = in_acc && (command == CMD_QUERY);
  assign wr_ext    = EXT_W'(entry_index);
  assign wr_en     = in_acc && (command == CMD_WRITE) && (wr_ext < MAX_EXT);
  assign wr_point  = '{x: x_coord, y: y_coord};
  assign rd_ext    = EXT_W'(scan_addr);
  assign issue     = (state == S_SCAN) && (scan_addr != scan_limit);

  nps_point_mem #(
    .DEPTH  (MAX_POINTS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ext[ADDR_W-1:0]),
    .wr_data (wr_point),
    .rd_addr (rd_ext[ADDR_W-1:0]),
    .rd_data (rd_point)
  );

  nps_dist_unit u_dist (
    .clk      (clk),
    .rst      (rst),
    .qx       (qx),
    .qy       (qy),
    .in_tag   (rd_tag),
    .in_point (rd_point),
    .sq_tag   (sq_tag),
    .sq       (sq),
    .busy     (dist_busy)
  );

  nps_isqrt u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (best_sq),
    .root  (root),
    .done  (root_done)
  );

  always_comb begin
    state_next = state;
    root_start = 1'b0;
    load       = 1'b0;
    case (state)
      S_IDLE: begin
        if (query_acc) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_tag.valid && !dist_busy) begin
          if (found) begin
            root_start = 1'b1;
            state_next = S_ROOT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ROOT: begin
        if (root_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_tag.index <= scan_addr + 1'b1;
    if (rst) begin
      state        <= S_IDLE;
      rd_tag.valid <= 1'b0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      rd_tag.valid <= issue;
      if (query_acc) begin
        found <= 1'b0;
      end else if (sq_tag.valid) begin
        found <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      qx         <= x_coord;
      qy         <= y_coord;
      scan_addr  <= '0;
      scan_limit <= (EXT_W'(reef_count) > MAX_EXT) ? MAX_EXT[CNT_W-1:0] : reef_count;
    end else if (issue) begin
      scan_addr <= scan_addr + 1'b1;
    end
    if (sq_tag.valid && (!found || (sq < best_sq))) begin
      best_sq  <= sq;
      best_idx <= sq_tag.index;
    end
    if (load) begin
      distance      <= found ? root : '1;
      nearest_index <= found ? best_idx : '0;
    end
  end

  `NPS_ASSERT_IMPLY(a_root_done_in_root, clk, rst, root_done, state == S_ROOT)
  `NPS_ASSERT_IMPLY(a_sq_only_in_scan, clk, rst, sq_tag.valid,
                    (state == S_SCAN) || (state == S_DRAIN))
  `NPS_ASSERT_IMPLY(a_empty_is_infinite, clk, rst, out_valid && (nearest_index == '0),
                    distance == '1)
  `NPS_ASSERT_NEXT(a_load_shows_result, clk, rst, load, out_valid)

endmodule
